/* sv/ptw_pkg.sv */
`default_nettype none

package ptw_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int WIN_AW     = $clog2(MAX_WINDOW);

    localparam int SAMPLE_W   = 16;
    localparam int TIME_W     = 32;
    localparam int STAT_W     = 32;
    localparam int CNT_W      = 7;
    localparam int IDX_W      = 6;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 192;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POST   = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_WINDOW = 1'b1;

    typedef enum logic [1:0] {
        OP_FEED,
        OP_FEED_DROP,
        OP_TRIG,
        OP_TRIG_DROP
    } ptw_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_RD,
        ST_LOAD
    } ptw_state_t;

    typedef struct packed {
        ptw_op_t             op;
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   time_now;
    } ptw_item_t;

    typedef struct packed {
        logic             clear;
        logic [CNT_W-1:0] pre;
        logic [CNT_W-1:0] post;
    } ptw_cfg_t;

    typedef struct packed {
        logic                kind;
        logic                accepted;
        logic                capturing;
        logic [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]    index;
        logic                last;
        logic [STAT_W-1:0]   window_tag;
        logic [TIME_W-1:0]   build_cycles;
        logic [CNT_W-1:0]    window_length;
    } ptw_result_t;

endpackage

`default_nettype wire

/* sv/pretrigger_window_capture.sv */
// A status word is registered: an accepted input word passes the two-entry queue and is
// then loaded into the output register; a trigger first copies the pre-trigger ring.
// Feeds and rejected items sustain 1 word per cycle while the output is not stalled; a
// completed window is emitted sample by sample (registered window buffer read, then output load).
// Reset (aresetn low, synchronous) and any write to a known configuration register clear all
// capture state and statistics at once; ring entries are cleared by valid bits, no clearing pass.
`default_nettype none

module pretrigger_window_capture (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ptw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ptw_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // sample_value[15:0], time_now[47:16]
    input  wire logic [ptw_pkg::IN_DATA_W-1:0]  s_tdata,
    // action
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // accepted[0], capturing[1], window_sample[17:2], window_index[23:18],
    // window_tag[55:24], build_cycles[87:56], window_length[94:88],
    // sample_drops[126:95], trigger_drops[158:127], window_count[190:159]
    output logic [ptw_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    // kind
    output logic                                m_tuser
);
    import ptw_pkg::*;

    ptw_cfg_t  cfg;
    ptw_item_t push_item;
    ptw_item_t pop_item;
    logic      push_valid;
    logic      push_ready;
    logic      pop_valid;
    logic      pop_ready;

    ptw_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .cfg_o      (cfg)
    );

    ptw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    ptw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_i    (cfg),
        .q_valid  (pop_valid),
        .q_pop    (pop_ready),
        .q_item   (pop_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_reset_no_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_STATUS)) |-> m_tlast)
        else $error("status word without tlast");

    a_window_not_cut: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && (m_tuser == KIND_WINDOW) && !m_tlast)
        |=> !(m_tvalid && (m_tuser == KIND_STATUS)))
        else $error("status word inside a window run");

    a_pop_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_ready |-> pop_valid)
        else $error("back end popped an empty queue");

endmodule

`default_nettype wire

/* sv/ptw_front.sv */
`default_nettype none

module ptw_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [ptw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ptw_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [ptw_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic                         s_tuser,
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output ptw_pkg::ptw_item_t                push_item,
    output ptw_pkg::ptw_cfg_t                 cfg_o
);
    import ptw_pkg::*;

    logic             enable_reg;
    logic [CNT_W-1:0] pre_reg;
    logic [CNT_W-1:0] post_reg;
    logic [CNT_W:0]   sum;
    logic             settings_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            pre_reg    <= '0;
            post_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ENABLE: enable_reg <= cfg_wdata[0];
                CFG_PRE:    pre_reg    <= cfg_wdata;
                CFG_POST:   post_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Any write to a known register wipes the capture state in the back end
    assign cfg_o.clear = cfg_wr_en &&
                         (cfg_index == CFG_ENABLE || cfg_index == CFG_PRE ||
                          cfg_index == CFG_POST);
    assign cfg_o.pre   = pre_reg;
    assign cfg_o.post  = post_reg;

    assign sum         = {1'b0, pre_reg} + {1'b0, post_reg};
    assign settings_ok = enable_reg && (sum != '0) && (sum <= (CNT_W+1)'(MAX_WINDOW));

    always_comb begin
        push_item.sample   = s_tdata[SAMPLE_W-1:0];
        push_item.time_now = s_tdata[SAMPLE_W +: TIME_W];
        if (s_tuser) begin
            push_item.op = settings_ok ? OP_TRIG : OP_TRIG_DROP;
        end else begin
            push_item.op = settings_ok ? OP_FEED : OP_FEED_DROP;
        end
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

`default_nettype wire

/* sv/ptw_queue.sv */
`default_nettype none

module ptw_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  ptw_pkg::ptw_item_t push_item,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output ptw_pkg::ptw_item_t pop_item
);
    import ptw_pkg::*;

    ptw_item_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* sv/ptw_back.sv */
`default_nettype none

module ptw_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  ptw_pkg::ptw_cfg_t                  cfg_i,
    input  wire logic                          q_valid,
    output logic                               q_pop,
    input  ptw_pkg::ptw_item_t                 q_item,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ptw_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tlast,
    output logic                               m_tuser
);
    import ptw_pkg::*;

    function automatic ptw_result_t status_word(input logic acc, input logic cap);
        ptw_result_t r;
        r           = '0;
        r.kind      = KIND_STATUS;
        r.accepted  = acc;
        r.capturing = cap;
        r.last      = 1'b1;
        return r;
    endfunction

    // Pre-trigger ring and window buffer
    logic [SAMPLE_W-1:0]   ring_mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] ring_vld_reg;
    logic [SAMPLE_W-1:0]   ring_rdata_reg;
    logic                  ring_rvld_reg;
    logic [SAMPLE_W-1:0]   win_mem [MAX_WINDOW];
    logic [SAMPLE_W-1:0]   win_rdata_reg;

    logic                ring_we;
    logic [WIN_AW-1:0]   ring_waddr;
    logic                ring_re;
    logic [WIN_AW-1:0]   ring_raddr;
    logic                win_we;
    logic [WIN_AW-1:0]   win_waddr;
    logic [SAMPLE_W-1:0] win_wdata;
    logic                win_re;
    logic [WIN_AW-1:0]   win_raddr;

    ptw_state_t        state_reg,     state_next;
    logic [WIN_AW-1:0] ring_head_reg, ring_head_next;
    logic [CNT_W-1:0]  post_coll_reg, post_coll_next;
    logic              capture_reg,   capture_next;
    logic [STAT_W-1:0] trace_reg,     trace_next;
    logic [TIME_W-1:0] trig_time_reg, trig_time_next;
    logic [STAT_W-1:0] drop_s_reg,    drop_s_next;
    logic [STAT_W-1:0] drop_t_reg,    drop_t_next;
    logic [STAT_W-1:0] done_reg,      done_next;
    logic [CNT_W-1:0]  cnt_reg,       cnt_next;
    logic [WIN_AW-1:0] src_reg,       src_next;
    logic [STAT_W-1:0] win_tid_reg,   win_tid_next;
    logic [TIME_W-1:0] win_delta_reg, win_delta_next;

    ptw_result_t out_reg;
    logic        out_vld_reg;
    logic        out_load;
    ptw_result_t load_val;
    logic        out_free;

    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] coll_inc;
    logic [CNT_W-1:0] win_pos;
    logic [CNT_W-1:0] head_inc;
    logic [CNT_W-1:0] src_inc;

    assign out_free = !out_vld_reg || m_tready;
    assign len      = cfg_i.pre + cfg_i.post;
    assign coll_inc = post_coll_reg + CNT_W'(1);
    assign win_pos  = cfg_i.pre + post_coll_reg;
    assign head_inc = CNT_W'(ring_head_reg) + CNT_W'(1);
    assign src_inc  = CNT_W'(src_reg) + CNT_W'(1);

    always_comb begin
        state_next     = state_reg;
        ring_head_next = ring_head_reg;
        post_coll_next = post_coll_reg;
        capture_next   = capture_reg;
        trace_next     = trace_reg;
        trig_time_next = trig_time_reg;
        drop_s_next    = drop_s_reg;
        drop_t_next    = drop_t_reg;
        done_next      = done_reg;
        cnt_next       = cnt_reg;
        src_next       = src_reg;
        win_tid_next   = win_tid_reg;
        win_delta_next = win_delta_reg;
        q_pop          = 1'b0;
        out_load       = 1'b0;
        load_val       = '0;
        ring_we        = 1'b0;
        ring_waddr     = ring_head_reg;
        ring_re        = 1'b0;
        ring_raddr     = src_reg;
        win_we         = 1'b0;
        win_waddr      = win_pos[WIN_AW-1:0];
        win_wdata      = q_item.sample;
        win_re         = 1'b0;
        win_raddr      = cnt_reg[WIN_AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    unique case (q_item.op)
                        OP_FEED_DROP: begin
                            drop_s_next = drop_s_reg + STAT_W'(1);
                            out_load    = 1'b1;
                            load_val    = status_word(1'b0, 1'b0);
                        end
                        OP_TRIG_DROP: begin
                            out_load = 1'b1;
                            load_val = status_word(1'b0, 1'b0);
                        end
                        OP_TRIG: begin
                            if (capture_reg) begin
                                drop_t_next = drop_t_reg + STAT_W'(1);
                                out_load    = 1'b1;
                                load_val    = status_word(1'b0, 1'b1);
                            end else begin
                                capture_next   = 1'b1;
                                post_coll_next = '0;
                                trig_time_next = q_item.time_now;
                                cnt_next       = '0;
                                src_next       = ring_head_reg;
                                state_next     = ST_COPY;
                            end
                        end
                        OP_FEED: begin
                            if (cfg_i.pre != '0) begin
                                ring_we        = 1'b1;
                                ring_head_next = (head_inc >= cfg_i.pre) ?
                                                 '0 : head_inc[WIN_AW-1:0];
                            end
                            if (capture_reg && (post_coll_reg < cfg_i.post)) begin
                                win_we         = 1'b1;
                                post_coll_next = coll_inc;
                            end
                            if (capture_reg && (post_coll_reg < cfg_i.post) &&
                                (coll_inc == cfg_i.post)) begin
                                // Window complete: latch its header and start emitting
                                win_tid_next   = trace_reg;
                                trace_next     = trace_reg + STAT_W'(1);
                                win_delta_next = q_item.time_now - trig_time_reg;
                                capture_next   = 1'b0;
                                done_next      = done_reg + STAT_W'(1);
                                cnt_next       = '0;
                                state_next     = ST_RD;
                            end else begin
                                out_load = 1'b1;
                                load_val = status_word(1'b1, capture_reg);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_COPY: begin
                // Read ring oldest first; write each word in the cycle after its read
                if (cnt_reg != cfg_i.pre) begin
                    ring_re  = 1'b1;
                    src_next = (src_inc >= cfg_i.pre) ? '0 : src_inc[WIN_AW-1:0];
                end
                if (cnt_reg != '0) begin
                    win_we    = 1'b1;
                    win_waddr = WIN_AW'(cnt_reg - CNT_W'(1));
                    win_wdata = ring_rvld_reg ? ring_rdata_reg : '0;
                end
                if (cnt_reg == cfg_i.pre) begin
                    out_load   = 1'b1;
                    load_val   = status_word(1'b1, 1'b1);
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_RD: begin
                win_re     = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    out_load               = 1'b1;
                    load_val.kind          = KIND_WINDOW;
                    load_val.accepted      = 1'b1;
                    load_val.capturing     = 1'b0;
                    load_val.sample        = win_rdata_reg;
                    load_val.index         = cnt_reg[IDX_W-1:0];
                    load_val.last          = (cnt_reg + CNT_W'(1) == len);
                    load_val.window_tag    = win_tid_reg;
                    load_val.build_cycles  = win_delta_reg;
                    load_val.window_length = len;
                    if (cnt_reg + CNT_W'(1) == len) begin
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_i.clear) begin
            state_reg     <= ST_IDLE;
            ring_head_reg <= '0;
            post_coll_reg <= '0;
            capture_reg   <= 1'b0;
            trace_reg     <= '0;
            trig_time_reg <= '0;
            drop_s_reg    <= '0;
            drop_t_reg    <= '0;
            done_reg      <= '0;
            cnt_reg       <= '0;
            src_reg       <= '0;
            ring_vld_reg  <= '0;
            out_vld_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ring_head_reg <= ring_head_next;
            post_coll_reg <= post_coll_next;
            capture_reg   <= capture_next;
            trace_reg     <= trace_next;
            trig_time_reg <= trig_time_next;
            drop_s_reg    <= drop_s_next;
            drop_t_reg    <= drop_t_next;
            done_reg      <= done_next;
            cnt_reg       <= cnt_next;
            src_reg       <= src_next;
            if (ring_we) begin
                ring_vld_reg[ring_waddr] <= 1'b1;
            end
            if (out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        win_tid_reg   <= win_tid_next;
        win_delta_reg <= win_delta_next;
        if (out_load) begin
            out_reg <= load_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= q_item.sample;
        end
        if (ring_re) begin
            ring_rdata_reg <= ring_mem[ring_raddr];
            ring_rvld_reg  <= ring_vld_reg[ring_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (win_we) begin
            win_mem[win_waddr] <= win_wdata;
        end
        if (win_re) begin
            win_rdata_reg <= win_mem[win_raddr];
        end
    end

    // Statistics are live: no new item is taken while a result of the last one waits
    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {1'b0, done_reg, drop_t_reg, drop_s_reg,
                       out_reg.window_length, out_reg.build_cycles, out_reg.window_tag,
                       out_reg.index, out_reg.sample, out_reg.capturing, out_reg.accepted};

endmodule

`default_nettype wire
